### rtl/gzc_pkg.sv
`timescale 1ns / 1ps

package gzc_pkg;

  // Default storage extents and ghost depth limit
  localparam int MAX_X_DEF     = 32;
  localparam int MAX_Y_DEF     = 32;
  localparam int MAX_Z_DEF     = 32;
  localparam int MAX_GHOST_DEF = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GHOST_DEPTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_ALL     = 3'd4;

  localparam logic [5:0] SIZE_RST  = 6'd32;
  localparam logic [3:0] DEPTH_RST = 4'd2;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Zone classes
  localparam logic [2:0] CLS_UNCOVERED = 3'd0;
  localparam logic [2:0] CLS_INTERIOR  = 3'd1;
  localparam logic [2:0] CLS_GHOST     = 3'd2;
  localparam logic [2:0] CLS_EDGE      = 3'd3;
  localparam logic [2:0] CLS_NEAR      = 3'd4;

  // Axial probe directions
  localparam logic [1:0] AX_XM    = 2'd0;
  localparam logic [1:0] AX_XP    = 2'd1;
  localparam logic [1:0] AX_YM    = 2'd2;
  localparam logic [1:0] AX_YP    = 2'd3;
  localparam logic [1:0] DIR_LAST = 2'd3;

  // Beat payloads
  typedef struct packed {
    logic       command;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [4:0] cell_z;
    logic       covered;
  } in_item_t;

  typedef struct packed {
    logic [2:0] zone_class;
    logic       selected;
  } out_item_t;

  // Neighbor coordinate, covers -16 .. 47
  typedef logic signed [6:0] coord_t;

  typedef enum logic [1:0] {
    PK_CENTER,
    PK_AXIAL,
    PK_DIAG
  } probe_kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_RD,
    S_WR_WR,
    S_CENTER,
    S_AXIAL,
    S_DIAG,
    S_DRAIN,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic        load_item;
    logic        clear_en;
    logic        wr_rd;
    logic        wr_we;
    logic        probe_en;
    probe_kind_t probe_kind;
    logic [3:0]  probe_g;
    logic [1:0]  probe_dir;
    logic        out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       out_free;
    logic [3:0] depth;
  } dp_status_t;

  // Coordinate lies in [0, lim)
  function automatic logic in_range(input coord_t c, input logic [5:0] lim);
    return (c >= 7'sd0) && (c < coord_t'({1'b0, lim}));
  endfunction

endpackage

### rtl/gzc_ctrl.sv
`timescale 1ns / 1ps

module gzc_ctrl import gzc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_query,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd,
  output logic       in_stall
);

  state_t     state_r, state_nxt;
  logic [3:0] g_r, g_nxt;
  logic [1:0] dir_r, dir_nxt;

  // State and probe counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      g_r     <= '0;
      dir_r   <= '0;
    end else begin
      state_r <= state_nxt;
      g_r     <= g_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    dir_nxt   = dir_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = in_query ? S_CENTER : S_WR_RD;
      end
      S_WR_RD: state_nxt = S_WR_WR;
      S_WR_WR: state_nxt = S_DONE;
      S_CENTER: begin
        state_nxt = S_AXIAL;
        g_nxt     = 4'd1;
        dir_nxt   = '0;
      end
      S_AXIAL: begin
        dir_nxt = dir_r + 2'd1;
        if (dir_r == DIR_LAST) begin
          if (g_r == sts.depth) begin
            state_nxt = S_DIAG;
            g_nxt     = 4'd1;
          end else begin
            g_nxt = g_r + 4'd1;
          end
        end
      end
      S_DIAG: begin
        dir_nxt = dir_r + 2'd1;
        if (dir_r == DIR_LAST) begin
          if (g_r == sts.depth) begin
            state_nxt = S_DRAIN;
          end else begin
            g_nxt = g_r + 4'd1;
          end
        end
      end
      // last probe's row is evaluated here
      S_DRAIN: state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: cmd.clear_en  = 1'b1;
      S_IDLE:  cmd.load_item = in_valid;
      S_WR_RD: cmd.wr_rd     = 1'b1;
      S_WR_WR: cmd.wr_we     = 1'b1;
      S_CENTER: begin
        cmd.probe_en   = 1'b1;
        cmd.probe_kind = PK_CENTER;
      end
      S_AXIAL: begin
        cmd.probe_en   = 1'b1;
        cmd.probe_kind = PK_AXIAL;
        cmd.probe_g    = g_r;
        cmd.probe_dir  = dir_r;
      end
      S_DIAG: begin
        cmd.probe_en   = 1'b1;
        cmd.probe_kind = PK_DIAG;
        cmd.probe_g    = g_r;
        cmd.probe_dir  = dir_r;
      end
      S_DONE:  cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/gzc_dp.sv
`timescale 1ns / 1ps

module gzc_dp import gzc_pkg::*; #(
  parameter int MAX_X     = MAX_X_DEF,
  parameter int MAX_Y     = MAX_Y_DEF,
  parameter int MAX_Z     = MAX_Z_DEF,
  parameter int MAX_GHOST = MAX_GHOST_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_item,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  localparam int XW   = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int AW   = XW + YW;
  localparam int ROWS = 1 << AW;

  // One memory row holds the covered bits of a z column
  logic [MAX_Z-1:0] mem [ROWS];

  logic [5:0]       size_x_r, size_y_r, size_z_r;
  logic [3:0]       depth_r;
  logic             sel_all_r;
  logic [5:0]       sx, sy, sz;
  logic [3:0]       dep;
  in_item_t         item_r;
  logic [AW-1:0]    clr_cnt_r;
  logic [MAX_Z-1:0] rdata_r;
  logic             meta_valid_r;
  probe_kind_t      meta_kind_r;
  logic [3:0]       meta_g_r;
  logic             meta_inb_r;
  logic             cov_r, edge_r, ghost_r, near_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  coord_t           cx, cy, cz, gc, px, py, mg;
  logic             row_inb, probe_inb, item_in_max;
  logic [AW-1:0]    probe_row, item_row, raddr, waddr;
  logic             we;
  logic [MAX_Z-1:0] wrow, wdata;
  logic             hit_cov, hit_edge, hit_ghost, hit_near;
  logic [2:0]       cls;
  logic             sel;

  function automatic logic z_hole(input logic [MAX_Z-1:0] row, input coord_t k,
                                  input logic [5:0] lim);
    return in_range(k, lim) && !row[ZW'(k[5:0])];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r  <= SIZE_RST;
      size_y_r  <= SIZE_RST;
      size_z_r  <= SIZE_RST;
      depth_r   <= DEPTH_RST;
      sel_all_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X:      size_x_r  <= cfg_wdata;
        REG_SIZE_Y:      size_y_r  <= cfg_wdata;
        REG_SIZE_Z:      size_z_r  <= cfg_wdata;
        REG_GHOST_DEPTH: depth_r   <= cfg_wdata[3:0];
        REG_SEL_ALL:     sel_all_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective extents: zero acts as one, limited by storage
  assign sx  = (size_x_r == '0) ? 6'd1 :
               ((int'(size_x_r) > MAX_X) ? 6'(MAX_X) : size_x_r);
  assign sy  = (size_y_r == '0) ? 6'd1 :
               ((int'(size_y_r) > MAX_Y) ? 6'(MAX_Y) : size_y_r);
  assign sz  = (size_z_r == '0) ? 6'd1 :
               ((int'(size_z_r) > MAX_Z) ? 6'(MAX_Z) : size_z_r);
  assign dep = (depth_r == '0) ? 4'd1 :
               ((int'(depth_r) > MAX_GHOST) ? 4'(MAX_GHOST) : depth_r);

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_item;
  end

  assign cx = coord_t'({2'b00, item_r.cell_x});
  assign cy = coord_t'({2'b00, item_r.cell_y});
  assign cz = coord_t'({2'b00, item_r.cell_z});
  assign gc = coord_t'({3'b000, cmd.probe_g});

  // Neighbor row for the current probe
  always_comb begin
    px = cx;
    py = cy;
    case (cmd.probe_kind)
      PK_AXIAL: begin
        case (cmd.probe_dir)
          AX_XM:   px = cx - gc;
          AX_XP:   px = cx + gc;
          AX_YM:   py = cy - gc;
          AX_YP:   py = cy + gc;
          default: ;
        endcase
      end
      PK_DIAG: begin
        px = cmd.probe_dir[0] ? cx + gc : cx - gc;
        py = cmd.probe_dir[1] ? cy + gc : cy - gc;
      end
      default: ;
    endcase
  end

  assign row_inb   = in_range(px, sx) && in_range(py, sy);
  assign probe_inb = (cmd.probe_kind == PK_CENTER) ? (row_inb && in_range(cz, sz))
                                                    : row_inb;
  assign probe_row = {XW'(px[5:0]), YW'(py[5:0])};
  assign item_row  = {XW'(item_r.cell_x), YW'(item_r.cell_y)};
  assign item_in_max = (int'(item_r.cell_x) < MAX_X) && (int'(item_r.cell_y) < MAX_Y) &&
                       (int'(item_r.cell_z) < MAX_Z);

  // Memory port muxing: clearing pass, read-modify-write, probes
  always_comb begin
    wrow = rdata_r;
    wrow[ZW'(item_r.cell_z)] = item_r.covered;
  end

  assign raddr = cmd.wr_rd ? item_row : probe_row;
  assign we    = cmd.clear_en || (cmd.wr_we && item_in_max);
  assign waddr = cmd.clear_en ? clr_cnt_r : item_row;
  assign wdata = cmd.clear_en ? '0 : wrow;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Clearing pass row counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clear_en) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // Probe tag, aligned with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) meta_valid_r <= 1'b0;
    else        meta_valid_r <= cmd.probe_en;
  end

  always_ff @(posedge clk) begin
    meta_kind_r <= cmd.probe_kind;
    meta_g_r    <= cmd.probe_g;
    meta_inb_r  <= probe_inb;
  end

  assign mg = coord_t'({3'b000, meta_g_r});

  // Hole detection on the returned row
  always_comb begin
    logic hole;
    hole      = 1'b0;
    hit_cov   = 1'b0;
    hit_edge  = 1'b0;
    hit_ghost = 1'b0;
    hit_near  = 1'b0;
    if (meta_valid_r) begin
      case (meta_kind_r)
        PK_CENTER: begin
          hit_cov = meta_inb_r && rdata_r[ZW'(item_r.cell_z)];
          // z-axis neighbors share the center row
          for (int g = 1; g <= MAX_GHOST; g++) begin
            if (g <= int'(dep)) begin
              hole = z_hole(rdata_r, cz - coord_t'(g), sz) ||
                     z_hole(rdata_r, cz + coord_t'(g), sz);
              if (g == 1) hit_edge  = hit_edge  || hole;
              else        hit_ghost = hit_ghost || hole;
            end
          end
        end
        PK_AXIAL: begin
          hole = meta_inb_r && !rdata_r[ZW'(item_r.cell_z)];
          if (meta_g_r == 4'd1) hit_edge  = hole;
          else                  hit_ghost = hole;
        end
        PK_DIAG: begin
          hit_near = meta_inb_r && (z_hole(rdata_r, cz - mg, sz) ||
                                    z_hole(rdata_r, cz + mg, sz));
        end
        default: ;
      endcase
    end
  end

  // Accumulated classification flags
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cov_r   <= 1'b0;
      edge_r  <= 1'b0;
      ghost_r <= 1'b0;
      near_r  <= 1'b0;
    end else begin
      cov_r   <= cov_r   || hit_cov;
      edge_r  <= edge_r  || hit_edge;
      ghost_r <= ghost_r || hit_ghost;
      near_r  <= near_r  || hit_near;
    end
  end

  // Priority: uncovered, edge, ghost, near-edge, interior
  always_comb begin
    if (!cov_r)       cls = CLS_UNCOVERED;
    else if (edge_r)  cls = CLS_EDGE;
    else if (ghost_r) cls = CLS_GHOST;
    else if (near_r)  cls = CLS_NEAR;
    else              cls = CLS_INTERIOR;
  end

  assign sel = (cls != CLS_UNCOVERED) && ((cls != CLS_INTERIOR) || sel_all_r);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)                       out_valid_r <= 1'b0;
    else if (cmd.out_load)            out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.zone_class <= cls;
      out_item_r.selected   <= sel;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign sts.clr_last = &clr_cnt_r;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.depth    = dep;

endmodule

### rtl/ghost_zone_classifier_3d.sv
`timescale 1ns / 1ps

// Covered-cell bitmap with ghost-zone classification.
// Input channel (in_valid/in_stall/in_item): a write beat sets or clears the
// covered bit of one cell; a query beat classifies one cell. Every input beat
// yields exactly one output beat (out_valid/out_stall/out_item), in order;
// writes return class uncovered, not selected.
// The bitmap is a memory of MAX_X*MAX_Y rows of MAX_Z bits with one read and
// one write port; a query reads one row per cycle: the center row (z neighbors),
// four axial rows and four diagonal rows per distance. One item at a time:
//   write: read the row, then write it back, then load the output.
//   query: probe rows out to the effective ghost depth, drain the last probe,
//   then load the output register as soon as it is free.
// Reset: synchronous, active low. After reset a clearing pass writes zeros to
// all 2^(clog2(MAX_X)+clog2(MAX_Y)) rows (1024 by default) with
// in_stall high; configuration writes are taken throughout.
// The result sits in an output register: if the receiver stalls, the next
// item is still accepted and worked on, and only its final load waits.
// Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once and
// are meant for idle periods.

module ghost_zone_classifier_3d import gzc_pkg::*; #(
  parameter int MAX_X     = MAX_X_DEF,
  parameter int MAX_Y     = MAX_Y_DEF,
  parameter int MAX_Z     = MAX_Z_DEF,
  parameter int MAX_GHOST = MAX_GHOST_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  gzc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_query (in_item.command == CMD_QUERY),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  gzc_dp #(
    .MAX_X     (MAX_X),
    .MAX_Y     (MAX_Y),
    .MAX_Z     (MAX_Z),
    .MAX_GHOST (MAX_GHOST)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // One item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous item still in progress");

  // Clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> in_stall)
    else $error("input not stalled during clearing pass");

  // Uncovered cells are never selected
  a_sel_needs_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.zone_class != CLS_UNCOVERED || !out_item.selected))
    else $error("uncovered cell marked selected");

  // Class code stays within the defined set
  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.zone_class == CLS_UNCOVERED ||
                   out_item.zone_class == CLS_INTERIOR ||
                   out_item.zone_class == CLS_GHOST ||
                   out_item.zone_class == CLS_EDGE ||
                   out_item.zone_class == CLS_NEAR))
    else $error("undefined zone class on output");

endmodule
